// ===== src/blot_pkg.sv =====
// ----------------------------------------------------------------------------
// blot_pkg: shared definitions for the bucketed log-order table
// Field widths, status codes, parameter defaults and the sequencer states.
// ----------------------------------------------------------------------------
package blot_pkg;

  localparam int CHUNK_W  = 20;
  localparam int ORDER_W  = 32;
  localparam int STATUS_W = 2;
  localparam int BUCKET_W = 6;
  localparam int SLOT_W   = 3;

  localparam int BUCKETS_DEFAULT = 64;
  localparam int ENTRIES_DEFAULT = 8;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t STATUS_NEW     = 2'd0;
  localparam status_t STATUS_UPDATED = 2'd1;
  localparam status_t STATUS_FULL    = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_LOOKUP,
    ST_FILL,
    ST_SCAN,
    ST_WRITE,
    ST_DONE
  } state_t;

endpackage

// ===== src/bucketed_log_order_table_core.sv =====
// ----------------------------------------------------------------------------
// bucketed_log_order_table_core: insert or update of chunk log orders
// A word (chunk_num, log_order) is accepted when start is high and busy is
// low. Each bucket keeps a fill count; one shared compare unit walks the
// occupied slots of the bucket, one slot per cycle from the chunk memory.
// After reset the fill counts are cleared in a pass over all buckets with
// busy high. When BUCKETS is a power of two the bucket is the low bits of
// chunk_num; any other BUCKETS adds a division that forms the remainder by
// a reciprocal multiply, a multiply and subtract, and a final compare and
// subtract. The scan stops at the matching slot or the last occupied one;
// an empty bucket skips the scan, and a full bucket refuses the item with
// no scan or write. The result is shown for one cycle with done high; the
// receiver cannot stall it.
// ----------------------------------------------------------------------------
module bucketed_log_order_table_core #(
  parameter int BUCKETS = blot_pkg::BUCKETS_DEFAULT,
  parameter int ENTRIES = blot_pkg::ENTRIES_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [blot_pkg::CHUNK_W-1:0]   chunk_num,
  input  logic [blot_pkg::ORDER_W-1:0]   log_order,
  output logic                           done,
  output logic [blot_pkg::STATUS_W-1:0]  status,
  output logic [blot_pkg::BUCKET_W-1:0]  bucket,
  output logic [blot_pkg::SLOT_W-1:0]    slot
);

  localparam int  BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int  SW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int  FW    = $clog2(ENTRIES + 1);
  localparam int  DEPTH = BUCKETS * ENTRIES;
  localparam int  AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int  DW    = 2 * blot_pkg::CHUNK_W;
  localparam bit  POW2  = (BUCKETS & (BUCKETS - 1)) == 0;

  localparam logic [BW:0]   BUCKETS_T = (BW+1)'(BUCKETS);
  localparam logic [FW-1:0] ENTRIES_F = FW'(ENTRIES);
  localparam logic [blot_pkg::CHUNK_W-1:0] DIV_M =
    blot_pkg::CHUNK_W'((1 << blot_pkg::CHUNK_W) / BUCKETS);
  localparam logic [blot_pkg::CHUNK_W-1:0] BUCKETS_C = blot_pkg::CHUNK_W'(BUCKETS);
  localparam logic [1:0]    DIV_LAST  = 2'd2;

  blot_pkg::state_t state, state_next;

  logic [blot_pkg::CHUNK_W-1:0] id_reg;
  logic [blot_pkg::ORDER_W-1:0] order_reg;
  logic [BW-1:0]                bucket_reg;
  logic [1:0]                   div_step;
  logic [blot_pkg::CHUNK_W-1:0] quo_reg;
  logic [BW:0]                  rem_reg;
  logic [AW-1:0]                base_reg;
  logic [SW-1:0]                slot_idx;
  logic [SW-1:0]                slot_next;
  logic [SW-1:0]                slot_reg;
  blot_pkg::status_t            status_reg;
  logic [BW-1:0]                clr_idx;

  logic [blot_pkg::CHUNK_W-1:0] chunk_mem [DEPTH];
  logic [blot_pkg::ORDER_W-1:0] order_mem [DEPTH];
  logic [FW-1:0]                fill_mem  [BUCKETS];
  logic [blot_pkg::CHUNK_W-1:0] chunk_q;
  logic [FW-1:0]                fill_q;

  logic [DW-1:0]                div_prod;
  logic [blot_pkg::CHUNK_W-1:0] rem_full;
  logic           rem_ge;
  logic [AW-1:0]  base_prod;
  logic [AW-1:0]  rd_addr;
  logic [AW-1:0]  wr_addr;
  logic           bucket_full;
  logic           bucket_empty;
  logic           scan_match;
  logic           scan_last;
  logic           accept;
  logic           clear_we;
  logic           entry_we;
  logic           fill_we;
  logic [31:0]    bucket_ext;
  logic [31:0]    slot_ext;

  assign div_prod     = DW'(id_reg) * DW'(DIV_M);
  assign rem_full     = id_reg - quo_reg * BUCKETS_C;
  assign rem_ge       = rem_reg >= BUCKETS_T;
  assign base_prod    = AW'(bucket_reg) * AW'(ENTRIES);
  assign bucket_full  = fill_q == ENTRIES_F;
  assign bucket_empty = fill_q == '0;
  assign scan_match   = chunk_q == id_reg;
  assign scan_last    = (FW'(slot_idx) + FW'(1)) == fill_q;
  assign accept       = start && !busy;
  assign rd_addr      = base_reg + AW'(slot_next);
  assign wr_addr      = base_reg + AW'(slot_reg);

  always_comb begin
    case (state)
      blot_pkg::ST_FILL: slot_next = '0;
      blot_pkg::ST_SCAN: slot_next = slot_idx + SW'(1);
      default:           slot_next = slot_idx;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      blot_pkg::ST_CLEAR: begin
        if (clr_idx == BW'(BUCKETS - 1)) state_next = blot_pkg::ST_IDLE;
      end
      blot_pkg::ST_IDLE: begin
        if (start) state_next = POW2 ? blot_pkg::ST_LOOKUP : blot_pkg::ST_DIV;
      end
      blot_pkg::ST_DIV: begin
        if (div_step == DIV_LAST) state_next = blot_pkg::ST_LOOKUP;
      end
      blot_pkg::ST_LOOKUP: state_next = blot_pkg::ST_FILL;
      blot_pkg::ST_FILL: begin
        if (bucket_full)       state_next = blot_pkg::ST_DONE;
        else if (bucket_empty) state_next = blot_pkg::ST_WRITE;
        else                   state_next = blot_pkg::ST_SCAN;
      end
      blot_pkg::ST_SCAN: begin
        if (scan_match || scan_last) state_next = blot_pkg::ST_WRITE;
      end
      blot_pkg::ST_WRITE: state_next = blot_pkg::ST_DONE;
      blot_pkg::ST_DONE:  state_next = blot_pkg::ST_IDLE;
      default:            state_next = blot_pkg::ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    busy     = 1'b1;
    done     = 1'b0;
    clear_we = 1'b0;
    entry_we = 1'b0;
    fill_we  = 1'b0;
    case (state)
      blot_pkg::ST_IDLE:  busy = 1'b0;
      blot_pkg::ST_CLEAR: clear_we = 1'b1;
      blot_pkg::ST_WRITE: begin
        entry_we = 1'b1;
        fill_we  = status_reg == blot_pkg::STATUS_NEW;
      end
      blot_pkg::ST_DONE:  done = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= blot_pkg::ST_CLEAR;
      clr_idx <= '0;
    end else begin
      state <= state_next;
      if (clear_we) clr_idx <= clr_idx + BW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      id_reg     <= chunk_num;
      order_reg  <= log_order;
      bucket_reg <= POW2 ? BW'(chunk_num & blot_pkg::CHUNK_W'(BUCKETS - 1)) : '0;
      div_step   <= '0;
    end
    case (state)
      blot_pkg::ST_DIV: begin
        case (div_step)
          2'd0:    quo_reg    <= div_prod[DW-1:blot_pkg::CHUNK_W];
          2'd1:    rem_reg    <= rem_full[BW:0];
          default: bucket_reg <= rem_ge ? BW'(rem_reg - BUCKETS_T) : BW'(rem_reg);
        endcase
        div_step <= div_step + 2'd1;
      end
      blot_pkg::ST_LOOKUP: base_reg <= base_prod;
      blot_pkg::ST_FILL: begin
        slot_idx <= '0;
        slot_reg <= '0;
        if (bucket_full) status_reg <= blot_pkg::STATUS_FULL;
        else             status_reg <= blot_pkg::STATUS_NEW;
      end
      blot_pkg::ST_SCAN: begin
        if (scan_match) begin
          status_reg <= blot_pkg::STATUS_UPDATED;
          slot_reg   <= slot_idx;
        end else if (scan_last) begin
          status_reg <= blot_pkg::STATUS_NEW;
          slot_reg   <= SW'(fill_q);
        end else begin
          slot_idx <= slot_next;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    chunk_q <= chunk_mem[rd_addr];
    if (entry_we) begin
      chunk_mem[wr_addr] <= id_reg;
      order_mem[wr_addr] <= order_reg;
    end
  end

  always_ff @(posedge clk) begin
    fill_q <= fill_mem[bucket_reg];
    if (clear_we)     fill_mem[clr_idx]    <= '0;
    else if (fill_we) fill_mem[bucket_reg] <= fill_q + FW'(1);
  end

  assign bucket_ext = 32'(bucket_reg);
  assign slot_ext   = 32'(slot_reg);
  assign status     = status_reg;
  assign bucket     = bucket_ext[blot_pkg::BUCKET_W-1:0];
  assign slot       = slot_ext[blot_pkg::SLOT_W-1:0];

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accepted word did not raise busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held longer than one cycle");

  a_full_slot: assert property (@(posedge clk) disable iff (rst)
    done && status == blot_pkg::STATUS_FULL |-> slot == '0)
    else $error("full bucket reported a nonzero slot");

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    state == blot_pkg::ST_FILL |-> fill_q <= ENTRIES_F)
    else $error("bucket fill count beyond slot count");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    state == blot_pkg::ST_SCAN |-> FW'(slot_idx) < fill_q)
    else $error("scan passed the occupied slots");

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for bucketed_log_order_table_core
// Drives (chunk_num, log_order) words through the start/busy handshake and
// keeps a shadow of the bucket table to predict status, bucket and slot.
// Each done strobe is checked against the oldest prediction. The directed
// words fill one bucket up to refusal and hit field extremes. The random
// words reuse earlier chunks and crowd a subset of buckets so that inserts,
// in-place updates and full-bucket refusals all occur. Sender idling runs
// at 7, then 49, then 0 percent.
// ----------------------------------------------------------------------------
module tb;

  localparam int TB_BUCKETS = blot_pkg::BUCKETS_DEFAULT;
  localparam int TB_ENTRIES = blot_pkg::ENTRIES_DEFAULT;
  localparam int TB_SLOTS   = TB_BUCKETS * TB_ENTRIES;

  typedef struct {
    logic [blot_pkg::CHUNK_W-1:0] chunk_num;
    logic [blot_pkg::ORDER_W-1:0] log_order;
  } log_word_t;

  typedef struct {
    blot_pkg::status_t             status;
    logic [blot_pkg::BUCKET_W-1:0] bucket;
    logic [blot_pkg::SLOT_W-1:0]   slot;
  } log_result_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          start = 1'b0;
  logic [blot_pkg::CHUNK_W-1:0]  chunk_num = '0;
  logic [blot_pkg::ORDER_W-1:0]  log_order = '0;
  logic                          busy;
  logic                          done;
  logic [blot_pkg::STATUS_W-1:0] status;
  logic [blot_pkg::BUCKET_W-1:0] bucket;
  logic [blot_pkg::SLOT_W-1:0]   slot;

  bit                           slot_used      [TB_SLOTS];
  logic [blot_pkg::CHUNK_W-1:0] slot_chunk_num [TB_SLOTS];
  logic [blot_pkg::ORDER_W-1:0] slot_log_order [TB_SLOTS];

  log_word_t    pending_words[$];
  log_result_t  expected_results[$];
  logic [blot_pkg::CHUNK_W-1:0] sent_ids[$];

  int send_idle_pct = 7;
  int words_accepted = 0;
  int n_inserted = 0;
  int n_updated = 0;
  int n_refused = 0;
  int mismatches = 0;

  bucketed_log_order_table_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .chunk_num (chunk_num),
    .log_order (log_order),
    .done      (done),
    .status    (status),
    .bucket    (bucket),
    .slot      (slot)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic log_result_t predict_update(
    input logic [blot_pkg::CHUNK_W-1:0] id,
    input logic [blot_pkg::ORDER_W-1:0] order
  );
    log_result_t r;
    int base;
    int idx;
    bit hit;
    r.bucket = blot_pkg::BUCKET_W'(id % TB_BUCKETS);
    r.slot = '0;
    r.status = blot_pkg::STATUS_FULL;
    base = int'(id % TB_BUCKETS) * TB_ENTRIES;
    if (!slot_used[base + TB_ENTRIES - 1]) begin
      idx = TB_ENTRIES - 1;
      hit = 1'b0;
      for (int i = 0; i < TB_ENTRIES; i++) begin
        if (!hit && !slot_used[base + i]) begin
          hit = 1'b1;
          idx = i;
          r.status = blot_pkg::STATUS_NEW;
        end else if (!hit && slot_chunk_num[base + i] == id) begin
          hit = 1'b1;
          idx = i;
          r.status = blot_pkg::STATUS_UPDATED;
        end
      end
      r.slot = blot_pkg::SLOT_W'(idx);
      slot_used[base + idx] = 1'b1;
      slot_chunk_num[base + idx] = id;
      slot_log_order[base + idx] = order;
    end
    return r;
  endfunction

  always @(posedge clk) begin : driver
    log_word_t nxt;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_results.push_back(predict_update(chunk_num, log_order));
        words_accepted++;
      end
      if (!start || !busy) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_words.pop_front();
          start <= 1'b1;
          chunk_num <= nxt.chunk_num;
          log_order <= nxt.log_order;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    log_result_t want;
    if (!rst && done !== 1'b0) begin
      if (expected_results.size() == 0) begin
        if (mismatches < 10)
          $display("ERROR: result with none pending: status %0d bucket %0d slot %0d",
                   status, bucket, slot);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (status !== want.status || bucket !== want.bucket || slot !== want.slot) begin
          if (mismatches < 10)
            $display("ERROR: expected status %0d bucket %0d slot %0d, got %0d %0d %0d",
                     want.status, want.bucket, want.slot, status, bucket, slot);
          mismatches++;
        end
        case (want.status)
          blot_pkg::STATUS_NEW:     n_inserted++;
          blot_pkg::STATUS_UPDATED: n_updated++;
          default:                  n_refused++;
        endcase
      end
    end
  end

  task automatic push_word(input logic [blot_pkg::CHUNK_W-1:0] id,
                           input logic [blot_pkg::ORDER_W-1:0] order);
    log_word_t w;
    w.chunk_num = id;
    w.log_order = order;
    pending_words.push_back(w);
    sent_ids.push_back(id);
  endtask

  // mix reused chunks, crowded buckets and fully random chunks
  task automatic push_random_words(input int count);
    logic [blot_pkg::CHUNK_W-1:0] id;
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 35 && sent_ids.size() != 0)
        id = sent_ids[$urandom_range(sent_ids.size() - 1)];
      else if (pick < 80)
        id = blot_pkg::CHUNK_W'($urandom_range(16383) * TB_BUCKETS + $urandom_range(31));
      else
        id = blot_pkg::CHUNK_W'($urandom_range(20'hFFFFF));
      push_word(id, $urandom);
    end
  endtask

  task automatic wait_drained;
    while (pending_words.size() != 0 || start || expected_results.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    push_word(20'h00000, 32'h00000000);
    push_word(20'hFFFFF, 32'hFFFFFFFF);
    push_word(20'h00000, 32'hFFFFFFFF);
    push_word(20'h00040, 32'h00000001);
    push_word(20'h00000, 32'h00000002);
    push_word(20'h00040, 32'h00000003);
    for (int k = 2; k < TB_ENTRIES; k++)
      push_word(blot_pkg::CHUNK_W'(k * TB_BUCKETS), blot_pkg::ORDER_W'(k));
    push_word(20'h00200, 32'h00000005);
    push_word(20'h001C0, 32'h00000006);
    push_word(20'h00000, 32'h00000007);
    push_word(20'hFFFC0, 32'h80000000);
    push_word(20'hFFFFF, 32'h5555AAAA);
    push_word(20'hAAAAA, 32'h55555555);
    push_word(20'h55555, 32'hAAAAAAAA);

    push_random_words(260);
    wait_drained();
    send_idle_pct = 49;
    push_random_words(270);
    wait_drained();
    send_idle_pct = 0;
    push_random_words(270);
    wait_drained();
    repeat (40) @(posedge clk);

    if (expected_results.size() != 0) begin
      $display("ERROR: %0d results never arrived", expected_results.size());
      mismatches += expected_results.size();
    end
    $display("Accepted %0d words: %0d inserts, %0d in-place updates, %0d refusals",
             words_accepted, n_inserted, n_updated, n_refused);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("ERROR: timeout");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/blot_pkg.sv
src/bucketed_log_order_table_core.sv
bench/tb.sv
